// ===== rtl/keypad_longpress_scanner_core_macros.svh =====
// assertion helpers for the keypad long-press scanner
// both expect clk and arst_n in the module that uses them
`ifndef KEYPAD_LONGPRESS_SCANNER_CORE_MACROS_SVH
`define KEYPAD_LONGPRESS_SCANNER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KLS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define KLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_pkg
// Shared constants, types and the key code table of the keypad scanner.
// ----------------------------------------------------------------------------
package kls_pkg;

	// matrix geometry
	localparam int unsigned ROWS       = 3;
	localparam int unsigned COLUMNS    = 7;
	localparam int unsigned ADDR_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned ROW_SEL_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

	// field widths
	localparam int unsigned COL_W      = 3;
	localparam int unsigned LEVEL_W    = 3;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned CODE_W     = 10;
	localparam int unsigned ST_W       = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 1;

	// configuration registers and their reset values
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONGPRESS_TICKS = 1'b0,
		CFG_MODIFIER_CODE   = 1'b1
	} cfg_idx_t;

	localparam logic [HOLD_W-1:0] LONGPRESS_RESET = 16'd60;
	localparam logic [CODE_W-1:0] MODIFIER_RESET  = 10'd56;

	// per-key status
	typedef enum logic [ST_W-1:0] {
		ST_IDLE     = 2'd0,
		ST_ARMED    = 2'd1,
		ST_REPORTED = 2'd2
	} status_t;

	// event group owed by one key
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} kind_t;

	// steps within an event group
	localparam logic [1:0] LONG_MOD_DOWN  = 2'd0;
	localparam logic [1:0] LONG_KEY_DOWN  = 2'd1;
	localparam logic [1:0] LONG_KEY_UP    = 2'd2;
	localparam logic [1:0] LONG_MOD_UP    = 2'd3;
	localparam logic [1:0] SHORT_KEY_DOWN = 2'd0;
	localparam logic [1:0] SHORT_KEY_UP   = 2'd1;

	// event groups of one scanned column, handed from update to emitter
	typedef struct packed {
		kind_t [ROWS-1:0]                  kind;
		logic  [ROWS-1:0][CODE_W-1:0]      code;
	} job_t;

	// fixed key table, zero marks an unpopulated position
	localparam int unsigned TABLE_ROWS = 3;
	localparam int unsigned TABLE_COLS = 7;
	localparam logic [CODE_W-1:0] CODE_TABLE [TABLE_ROWS][TABLE_COLS] = '{
		'{10'd2, 10'd8, 10'd5, 10'd11, 10'd78, 10'd28, 10'd103},
		'{10'd7, 10'd4, 10'd10, 10'd0, 10'd74, 10'd1, 10'd108},
		'{10'd3, 10'd9, 10'd6, 10'd0, 10'd0, 10'd0, 10'd0}
	};

	function automatic logic [CODE_W-1:0] code_at(int unsigned row, int unsigned col);
		logic [CODE_W-1:0] c;
		c = '0;
		if (row < TABLE_ROWS && col < TABLE_COLS) begin
			c = CODE_TABLE[row][col];
		end
		return c;
	endfunction

endpackage

// ===== rtl/keypad_longpress_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_longpress_scanner_core
// Column-scanned keypad with long-press detection; per-key status and
// deadlines live in two RAMs addressed by column.
// ----------------------------------------------------------------------------
// path: stage 1 registers, then the emitter's job and output registers
// throughput: one column per cycle when it causes no events; otherwise the
//   column occupies the emitter until all its beats (up to 12 for 3 rows)
//   are sent, while the next column is read and updated behind it
// reset: key status reads idle at once (per-column valid bits), registers
//   return to 60 ticks and code 56; deadline RAM is not cleared
module keypad_longpress_scanner_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kls_pkg::COL_W-1:0]       column,
	input  logic [kls_pkg::LEVEL_W-1:0]     row_levels,
	input  logic [kls_pkg::TICK_W-1:0]      now,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kls_pkg::CODE_W-1:0]      key_code,
	output logic                            key_value,
	output logic                            sync_after,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [kls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kls_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import kls_pkg::*;

	logic [HOLD_W-1:0] longpress_ticks_q;
	logic [CODE_W-1:0] modifier_code_q;
	job_t              job;
	logic              job_load;
	logic              job_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			longpress_ticks_q <= LONGPRESS_RESET;
			modifier_code_q   <= MODIFIER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONGPRESS_TICKS: longpress_ticks_q <= cfg_data[HOLD_W-1:0];
				CFG_MODIFIER_CODE:   modifier_code_q   <= cfg_data[CODE_W-1:0];
				default: begin
					longpress_ticks_q <= longpress_ticks_q;
				end
			endcase
		end
	end

	// status read-modify-write
	kls_update u_update (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.column          (column),
		.row_levels      (row_levels),
		.now             (now),
		.longpress_ticks (longpress_ticks_q),
		.job_free        (job_free),
		.job             (job),
		.job_load        (job_load)
	);

	// event sequencing
	kls_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (job),
		.job_load      (job_load),
		.job_free      (job_free),
		.modifier_code (modifier_code_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.key_code      (key_code),
		.key_value     (key_value),
		.sync_after    (sync_after),
		.last          (last)
	);

endmodule

// ===== rtl/kls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kls_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/kls_update.sv =====
`timescale 1ns / 1ps
`include "keypad_longpress_scanner_core_macros.svh"
// ----------------------------------------------------------------------------
// kls_update
// Reads the status and deadline row of the scanned column, works out each
// key's transition and event group, and writes the row back.
// ----------------------------------------------------------------------------
module kls_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kls_pkg::COL_W-1:0]     column,
	input  logic [kls_pkg::LEVEL_W-1:0]   row_levels,
	input  logic [kls_pkg::TICK_W-1:0]    now,
	input  logic [kls_pkg::HOLD_W-1:0]    longpress_ticks,
	input  logic                          job_free,
	output kls_pkg::job_t                 job,
	output logic                          job_load
);
	import kls_pkg::*;

	localparam int unsigned ST_WORD_W = ROWS * ST_W;
	localparam int unsigned DL_WORD_W = ROWS * TICK_W;

	// input side
	logic                  accept;
	logic                  new_in_range;
	logic [ADDR_W-1:0]     new_addr;

	// stage 1 registers
	logic                  valid_s1;
	logic                  in_range_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [LEVEL_W-1:0]    levels_s1;
	logic [TICK_W-1:0]     now_s1;

	// status valid bits and write-to-read forwarding
	logic [COLUMNS-1:0]    st_valid_q;
	logic                  fwd_q;
	logic [ST_WORD_W-1:0]  fwd_st_q;
	logic [DL_WORD_W-1:0]  fwd_dl_q;
	logic                  fwd_match;

	// memory data
	logic [ST_WORD_W-1:0]  st_rd;
	logic [DL_WORD_W-1:0]  dl_rd;
	logic [ST_WORD_W-1:0]  st_word;
	logic [DL_WORD_W-1:0]  dl_word;
	logic [ST_WORD_W-1:0]  new_st_word;
	logic [DL_WORD_W-1:0]  new_dl_word;

	// control
	logic                  s1_adv;
	logic                  ram_we;
	logic                  job_empty;
	logic [TICK_W-1:0]     arm_dl;
	logic [ROWS+LEVEL_W-1:0] lv_ext;
	job_t                  job_c;

	// handshake and addressing
	assign accept       = in_valid && !in_stall;
	assign new_in_range = 32'(column) < COLUMNS;
	assign new_addr     = new_in_range ? ADDR_W'(column) : '0;
	assign s1_adv       = valid_s1 && (job_empty || job_free);
	assign in_stall     = valid_s1 && !s1_adv;
	assign ram_we       = s1_adv && in_range_s1;
	assign job_load     = s1_adv && !job_empty;
	assign job          = job_c;
	assign fwd_match    = ram_we && accept && new_in_range && (new_addr == addr_s1);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_q    <= fwd_match;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
				fwd_q    <= 1'b0;
			end
		end
	end

	// stage 1 payload and forwarded row
	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= new_in_range;
			addr_s1     <= new_addr;
			levels_s1   <= row_levels;
			now_s1      <= now;
		end
		if (fwd_match) begin
			fwd_st_q <= new_st_word;
			fwd_dl_q <= new_dl_word;
		end
	end

	// status rows count as idle until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid_q <= '0;
		end else if (ram_we) begin
			st_valid_q[addr_s1] <= 1'b1;
		end
	end

	// current row, newest data first
	always_comb begin
		st_word = fwd_q ? fwd_st_q : ((in_range_s1 && st_valid_q[addr_s1]) ? st_rd : '0);
		dl_word = fwd_q ? fwd_dl_q : dl_rd;
	end

	assign arm_dl = now_s1 + TICK_W'(longpress_ticks);
	assign lv_ext = {{ROWS{1'b1}}, levels_s1};

	// per-key transitions, rows are independent
	always_comb begin
		logic [CODE_W-1:0] code_r;
		logic [ST_W-1:0]   st_r;
		logic [TICK_W-1:0] dl_r;
		logic [TICK_W-1:0] diff_r;
		logic              passed_r;
		logic              pressed_r;
		new_st_word = st_word;
		new_dl_word = dl_word;
		job_empty   = 1'b1;
		for (int unsigned r = 0; r < ROWS; r++) begin
			code_r    = code_at(r, 32'(addr_s1));
			st_r      = st_word[r*ST_W +: ST_W];
			dl_r      = dl_word[r*TICK_W +: TICK_W];
			diff_r    = dl_r - now_s1;
			passed_r  = diff_r[TICK_W-1];
			pressed_r = !lv_ext[r];
			job_c.kind[r] = EV_NONE;
			job_c.code[r] = code_r;
			if (in_range_s1 && code_r != '0) begin
				if (pressed_r) begin
					if (st_r == ST_IDLE) begin
						new_st_word[r*ST_W +: ST_W]     = ST_ARMED;
						new_dl_word[r*TICK_W +: TICK_W] = arm_dl;
					end else if (st_r == ST_ARMED && passed_r) begin
						new_st_word[r*ST_W +: ST_W] = ST_REPORTED;
						job_c.kind[r]               = EV_LONG;
					end
				end else begin
					if (st_r == ST_ARMED) begin
						job_c.kind[r] = passed_r ? EV_LONG : EV_SHORT;
					end
					new_st_word[r*ST_W +: ST_W] = ST_IDLE;
				end
			end
			if (job_c.kind[r] != EV_NONE) begin
				job_empty = 1'b0;
			end
		end
	end

	// status rows, one per column
	kls_ram #(
		.WIDTH (ST_WORD_W),
		.DEPTH (COLUMNS)
	) u_st_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_st_word),
		.re    (accept),
		.raddr (new_addr),
		.rdata (st_rd)
	);

	// deadline rows, one per column
	kls_ram #(
		.WIDTH (DL_WORD_W),
		.DEPTH (COLUMNS)
	) u_dl_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_dl_word),
		.re    (accept),
		.raddr (new_addr),
		.rdata (dl_rd)
	);

	`KLS_ASSERT_IMPL(a_stall_needs_item, in_stall, valid_s1, "stall raised with stage 1 empty")
	`KLS_ASSERT_IMPL(a_fwd_needs_item, fwd_q, valid_s1 && in_range_s1, "forwarded row without an in-range item")
	`KLS_ASSERT_NEXT(a_adv_empties, s1_adv && !accept, !valid_s1, "stage 1 kept an item it handed on")

endmodule

// ===== rtl/kls_emitter.sv =====
`timescale 1ns / 1ps
`include "keypad_longpress_scanner_core_macros.svh"
// ----------------------------------------------------------------------------
// kls_emitter
// Holds the event groups of one column and, unless the output stalls, sends
// one beat per cycle through an output register, rows in ascending order.
// ----------------------------------------------------------------------------
module kls_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kls_pkg::job_t               job,
	input  logic                        job_load,
	output logic                        job_free,
	input  logic [kls_pkg::CODE_W-1:0]  modifier_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kls_pkg::CODE_W-1:0]  key_code,
	output logic                        key_value,
	output logic                        sync_after,
	output logic                        last
);
	import kls_pkg::*;

	// job held for emission
	logic                         job_valid_q;
	kind_t [ROWS-1:0]             kind_q;
	logic  [ROWS-1:0][CODE_W-1:0] code_q;
	logic  [1:0]                  step_q;

	// output register
	logic                         out_valid_q;
	logic [CODE_W-1:0]            key_code_q;
	logic                         key_value_q;
	logic                         sync_after_q;
	logic                         last_q;

	// next beat
	logic [ROW_SEL_W-1:0]         sel;
	logic [ROWS-1:0]              kind_nz;
	logic                         others;
	kind_t                        sel_kind;
	logic [CODE_W-1:0]            sel_code;
	logic [CODE_W-1:0]            ev_code;
	logic                         ev_value;
	logic                         ev_sync;
	logic                         group_end;
	logic                         ev_last;
	logic                         emit_fire;

	// lowest row still owing events
	always_comb begin
		sel = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			kind_nz[r] = (kind_q[r] != EV_NONE);
			if (kind_q[r] != EV_NONE) begin
				sel = ROW_SEL_W'(r);
			end
		end
		others   = |(kind_nz & ~(ROWS'(1) << sel));
		sel_kind = kind_q[sel];
		sel_code = code_q[sel];
	end

	// beat contents for the current step
	always_comb begin
		ev_code   = sel_code;
		ev_value  = 1'b0;
		ev_sync   = 1'b0;
		group_end = 1'b0;
		case (sel_kind)
			EV_LONG: begin
				case (step_q)
					LONG_MOD_DOWN: begin
						ev_code  = modifier_code;
						ev_value = 1'b1;
					end
					LONG_KEY_DOWN: begin
						ev_value = 1'b1;
					end
					LONG_KEY_UP: begin
						ev_value = 1'b0;
					end
					LONG_MOD_UP: begin
						ev_code   = modifier_code;
						ev_sync   = 1'b1;
						group_end = 1'b1;
					end
					default: begin
						ev_value = 1'b0;
					end
				endcase
			end
			EV_SHORT: begin
				case (step_q)
					SHORT_KEY_DOWN: begin
						ev_value = 1'b1;
					end
					SHORT_KEY_UP: begin
						ev_sync   = 1'b1;
						group_end = 1'b1;
					end
					default: begin
						ev_value = 1'b0;
					end
				endcase
			end
			default: begin
				ev_value = 1'b0;
			end
		endcase
		ev_last = group_end && !others;
	end

	assign emit_fire = job_valid_q && (!out_valid_q || !out_stall);
	assign job_free  = !job_valid_q || (emit_fire && ev_last);

	// job progress, a new job takes over in the cycle the old one ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			kind_q      <= '{default: EV_NONE};
			step_q      <= '0;
		end else if (job_load) begin
			job_valid_q <= 1'b1;
			kind_q      <= job.kind;
			step_q      <= '0;
		end else if (emit_fire) begin
			if (group_end) begin
				kind_q[sel] <= EV_NONE;
				step_q      <= '0;
			end else begin
				step_q <= step_q + 2'd1;
			end
			if (ev_last) begin
				job_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			code_q <= job.code;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			key_code_q   <= ev_code;
			key_value_q  <= ev_value;
			sync_after_q <= ev_sync;
			last_q       <= ev_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_code   = key_code_q;
	assign key_value  = key_value_q;
	assign sync_after = sync_after_q;
	assign last       = last_q;

	`KLS_ASSERT_IMPL(a_job_has_events, job_valid_q, |kind_nz, "held job owes no events")
	`KLS_ASSERT_IMPL(a_load_when_free, job_load, job_free, "job loaded over an unfinished one")
	`KLS_ASSERT_NEXT(a_last_ends_job, emit_fire && ev_last && !job_load, !job_valid_q, "job outlived its last beat")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keypad long-press scanner: scanned columns go
// in through a valid/stall channel, key event beats come back on another.
// A directed table covers reset values, hold boundaries, reserved positions
// and tick wrap; random phases under several hold/modifier settings then
// drive mostly realistic press/release patterns. Every beat is checked field
// by field against set outcomes or a prediction of key status and deadlines.
// ----------------------------------------------------------------------------
module tb;

	import kls_pkg::*;

	localparam int unsigned NUM_KEYS        = ROWS * COLUMNS;
	localparam int          IDLE_PCT        = 35;
	localparam int          SETTLE_CYCLES   = 10;
	localparam int          HOLD_OFF_CYCLES = 400;
	localparam int          STUCK_LIMIT     = 3000;
	localparam int unsigned JUNK_W          = CFG_DATA_W - CODE_W;
	localparam logic [HOLD_W-1:0] DEFAULT_HOLD     = 16'd60;
	localparam logic [CODE_W-1:0] DEFAULT_MODIFIER = 10'd56;

	// key codes by row * COLUMNS + column, zero for an empty position
	localparam logic [0:20][CODE_W-1:0] KEY_TABLE = {
		10'd2, 10'd8, 10'd5, 10'd11, 10'd78, 10'd28, 10'd103,
		10'd7, 10'd4, 10'd10, 10'd0, 10'd74, 10'd1, 10'd108,
		10'd3, 10'd9, 10'd6, 10'd0, 10'd0, 10'd0, 10'd0
	};

	// how a directed row's events are obtained
	typedef enum logic [1:0] {
		OUT_PREDICT = 2'd0,
		OUT_QUIET   = 2'd1,
		OUT_SHORT   = 2'd2,
		OUT_LONG    = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [LEVEL_W-1:0] levels;
		logic [TICK_W-1:0]  t;
		outcome_t           outcome;
		logic [CODE_W-1:0]  code;
	} scan_row_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              value;
		logic              sync;
		logic              last;
	} key_event_t;

	// default settings: hold 60 ticks, modifier 56
	localparam scan_row_t DIRECTED_ROWS [25] = '{
		'{3'd0, 3'b111, 32'd0,          OUT_QUIET,   10'd0},
		'{3'd7, 3'b000, 32'd5,          OUT_QUIET,   10'd0},
		'{3'd0, 3'b110, 32'd100,        OUT_QUIET,   10'd0},
		'{3'd0, 3'b111, 32'd130,        OUT_SHORT,   10'd2},
		'{3'd0, 3'b110, 32'd200,        OUT_QUIET,   10'd0},
		'{3'd0, 3'b110, 32'd260,        OUT_QUIET,   10'd0},
		'{3'd0, 3'b110, 32'd261,        OUT_LONG,    10'd2},
		'{3'd0, 3'b110, 32'd400,        OUT_QUIET,   10'd0},
		'{3'd0, 3'b111, 32'd401,        OUT_QUIET,   10'd0},
		'{3'd3, 3'b000, 32'd500,        OUT_QUIET,   10'd0},
		'{3'd3, 3'b111, 32'd700,        OUT_LONG,    10'd11},
		'{3'd6, 3'b000, 32'd1000,       OUT_QUIET,   10'd0},
		'{3'd6, 3'b000, 32'd1100,       OUT_PREDICT, 10'd0},
		'{3'd1, 3'b000, 32'd2000,       OUT_QUIET,   10'd0},
		'{3'd1, 3'b010, 32'd2010,       OUT_PREDICT, 10'd0},
		'{3'd1, 3'b111, 32'd2100,       OUT_PREDICT, 10'd0},
		'{3'd2, 3'b000, 32'hFFFF_FFF0,  OUT_QUIET,   10'd0},
		'{3'd2, 3'b000, 32'h0000_002C,  OUT_QUIET,   10'd0},
		'{3'd2, 3'b101, 32'h0000_002D,  OUT_PREDICT, 10'd0},
		'{3'd2, 3'b111, 32'h8000_0000,  OUT_QUIET,   10'd0},
		'{3'd5, 3'b000, 32'h7FFF_FFF0,  OUT_QUIET,   10'd0},
		'{3'd5, 3'b111, 32'h8000_0010,  OUT_PREDICT, 10'd0},
		'{3'd4, 3'b011, 32'd3000,       OUT_QUIET,   10'd0},
		'{3'd4, 3'b000, 32'hFFFF_FFFF,  OUT_QUIET,   10'd0},
		'{3'd4, 3'b111, 32'h7FFF_FFFF,  OUT_PREDICT, 10'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [COL_W-1:0]      column;
	logic [LEVEL_W-1:0]    row_levels;
	logic [TICK_W-1:0]     now;
	logic                  out_valid;
	logic                  out_stall;
	logic [CODE_W-1:0]     key_code;
	logic                  key_value;
	logic                  sync_after;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predicted key state and settings
	status_t           key_state [NUM_KEYS];
	logic [TICK_W-1:0] key_due [NUM_KEYS];
	logic [HOLD_W-1:0] hold_ticks;
	logic [CODE_W-1:0] modifier_code;

	key_event_t column_events [$];
	key_event_t owed_events [$];
	int         mismatches;
	bit         gaps_on;
	bit         hold_off_req;

	keypad_longpress_scanner_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.column     (column),
		.row_levels (row_levels),
		.now        (now),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_code   (key_code),
		.key_value  (key_value),
		.sync_after (sync_after),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void push_event(input logic [CODE_W-1:0] code, input logic value,
			input logic sync);
		column_events.push_back('{code, value, sync, 1'b0});
	endfunction

	function automatic void push_long(input logic [CODE_W-1:0] code,
			input logic [CODE_W-1:0] modifier);
		push_event(modifier, 1'b1, 1'b0);
		push_event(code, 1'b1, 1'b0);
		push_event(code, 1'b0, 1'b0);
		push_event(modifier, 1'b0, 1'b1);
	endfunction

	// update key status for one scanned column, leaving its events in column_events
	function automatic void scan_column(input logic [COL_W-1:0] col,
			input logic [LEVEL_W-1:0] levels, input logic [TICK_W-1:0] t);
		int                unsigned r;
		int                unsigned idx;
		logic [CODE_W-1:0] code;
		logic [TICK_W-1:0] gap;
		logic              late;
		column_events.delete();
		if (col >= COLUMNS) begin
			return;
		end
		for (r = 0; r < ROWS; r++) begin
			idx  = r * COLUMNS + col;
			code = KEY_TABLE[idx];
			if (code == '0) begin
				continue;
			end
			gap  = key_due[idx] - t;
			late = gap[TICK_W-1];
			if (!levels[r]) begin
				if (key_state[idx] == ST_IDLE) begin
					key_due[idx]   = t + TICK_W'(hold_ticks);
					key_state[idx] = ST_ARMED;
				end else if (key_state[idx] == ST_ARMED && late) begin
					push_long(code, modifier_code);
					key_state[idx] = ST_REPORTED;
				end
			end else begin
				if (key_state[idx] == ST_ARMED) begin
					if (late) begin
						push_long(code, modifier_code);
					end else begin
						push_event(code, 1'b1, 1'b0);
						push_event(code, 1'b0, 1'b1);
					end
				end
				key_state[idx] = ST_IDLE;
			end
		end
		if (column_events.size() > 0) begin
			column_events[$].last = 1'b1;
		end
	endfunction

	// offer one column beat, hold it until accepted, then record what it owes
	task automatic send_column(input logic [COL_W-1:0] col, input logic [LEVEL_W-1:0] levels,
			input logic [TICK_W-1:0] t, input outcome_t outcome, input logic [CODE_W-1:0] code);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		column     <= col;
		row_levels <= levels;
		now        <= t;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		scan_column(col, levels, t);
		if (outcome != OUT_PREDICT) begin
			column_events.delete();
			if (outcome == OUT_SHORT) begin
				push_event(code, 1'b1, 1'b0);
				push_event(code, 1'b0, 1'b1);
			end else if (outcome == OUT_LONG) begin
				push_long(code, DEFAULT_MODIFIER);
			end
			if (column_events.size() > 0) begin
				column_events[$].last = 1'b1;
			end
		end
		foreach (column_events[i]) begin
			owed_events.push_back(column_events[i]);
		end
	endtask

	// drain everything owed, then let any quiet column finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (owed_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers, modifier written with junk in the unused upper bits
	task automatic write_config(input logic [HOLD_W-1:0] hold, input logic [CODE_W-1:0] modifier);
		logic [JUNK_W-1:0] junk;
		junk = JUNK_W'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LONGPRESS_TICKS;
		cfg_data  <= hold;
		@(posedge clk);
		cfg_index <= CFG_MODIFIER_CODE;
		cfg_data  <= {junk, modifier};
		@(posedge clk);
		cfg_we        <= 1'b0;
		hold_ticks    = hold;
		modifier_code = modifier;
	endtask

	// random scanning: mostly keys held and released over advancing ticks, some noise
	task automatic run_scan_phase(input logic [HOLD_W-1:0] hold, input logic [CODE_W-1:0] modifier,
			input int count, input logic [TICK_W-1:0] start, input bit pressure, input bit gaps);
		logic [LEVEL_W-1:0] held [COLUMNS];
		logic [TICK_W-1:0]  scan_now;
		logic [COL_W-1:0]   col;
		int                 k;
		int                 r;
		wait_idle();
		write_config(hold, modifier);
		gaps_on  = gaps;
		scan_now = start;
		foreach (held[i]) begin
			held[i] = '0;
		end
		if (pressure) begin
			hold_off_req = 1'b1;
		end
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 10) begin
				send_column(COL_W'($urandom_range(7)), LEVEL_W'($urandom_range(7)), $urandom,
					OUT_PREDICT, '0);
			end else begin
				col = COL_W'($urandom_range(COLUMNS - 1));
				for (r = 0; r < LEVEL_W; r++) begin
					if ($urandom_range(99) < 25) begin
						held[col][r] = ~held[col][r];
					end
				end
				if ($urandom_range(99) < 80) begin
					scan_now += $urandom_range(hold / 3 + 2);
				end else begin
					scan_now += $urandom_range(2 * hold + 2, hold);
				end
				send_column(col, ~held[col], scan_now, OUT_PREDICT, '0);
			end
		end
	endtask

	// result side: check each accepted beat, stall at random or on request
	initial begin : beat_sink
		int         hold_left;
		key_event_t want;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (owed_events.size() == 0) begin
					$display("%0t: unexpected beat code %0d value %0b sync %0b last %0b",
						$time, key_code, key_value, sync_after, last);
					mismatches++;
				end else begin
					want = owed_events.pop_front();
					if (key_code !== want.code) begin
						$display("%0t: key_code expected %0d, got %0d", $time, want.code, key_code);
						mismatches++;
					end
					if (key_value !== want.value) begin
						$display("%0t: key_value expected %0b, got %0b", $time, want.value,
							key_value);
						mismatches++;
					end
					if (sync_after !== want.sync) begin
						$display("%0t: sync_after expected %0b, got %0b", $time, want.sync,
							sync_after);
						mismatches++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %0b, got %0b", $time, want.last, last);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
				out_stall    <= 1'b1;
			end else begin
				out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// watchdog on cycles without any accepted beat or register write
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAIL");
		$finish;
	end

	// reset, directed table, random phases, final verdict
	initial begin
		mismatches    = 0;
		gaps_on       = 1'b1;
		hold_off_req  = 1'b0;
		hold_ticks    = DEFAULT_HOLD;
		modifier_code = DEFAULT_MODIFIER;
		foreach (key_state[i]) begin
			key_state[i] = ST_IDLE;
			key_due[i]   = '0;
		end
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		column     <= '0;
		row_levels <= '1;
		now        <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_LONGPRESS_TICKS;
		cfg_data   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			send_column(DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].levels, DIRECTED_ROWS[i].t,
				DIRECTED_ROWS[i].outcome, DIRECTED_ROWS[i].code);
		end

		run_scan_phase(16'd1, 10'd0, 45, 32'h0000_1000, 1'b0, 1'b1);
		run_scan_phase(16'hFFFF, 10'h3FF, 50, 32'hFFFF_F000, 1'b1, 1'b1);
		run_scan_phase(16'd0, 10'd767, 45, 32'h7FFF_FFC0, 1'b0, 1'b0);
		run_scan_phase(HOLD_W'($urandom_range(65535, 1)), CODE_W'($urandom_range(767)), 55,
			$urandom, 1'b0, 1'b1);
		run_scan_phase(DEFAULT_HOLD, DEFAULT_MODIFIER, 50, $urandom, 1'b0, 1'b1);

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kls_pkg.sv
rtl/kls_ram.sv
rtl/kls_update.sv
rtl/kls_emitter.sv
rtl/keypad_longpress_scanner_core.sv
tb/sv/tb.sv
